// ===== rtl/ps2_mouse_packet_cursor_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// PS/2 cursor tracker assertion macros
// Short wrappers for the concurrent checks used in the tracker RTL.
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH

// same-cycle implication
`define PMCT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PMCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pmct_pkg.sv =====
// ----------------------------------------------------------------------------
// pmct_pkg
// Types and constants shared by the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package pmct_pkg;

   localparam int COORD_BITS_DEFAULT = 10;

   localparam int BYTE_W     = 8;
   localparam int OUT_W      = 10;  // cursor port width
   localparam int GFX_DIM_W  = 11;  // graphics width/height register width
   localparam int TXT_DIM_W  = 8;   // text width/height register width
   localparam int TXT_CALC_W = 10;  // signed text cursor arithmetic
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // header byte masks
   localparam logic [BYTE_W-1:0] SYNC_MASK     = 8'h08;
   localparam logic [BYTE_W-1:0] OVERFLOW_MASK = 8'hC0;
   localparam logic [BYTE_W-1:0] LEFT_MASK     = 8'h01;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRAPHICS_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GFX_WIDTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GFX_HEIGHT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_HEIGHT   = 3'd4;

   // register reset values
   localparam logic [GFX_DIM_W-1:0] GFX_WIDTH_RESET   = 11'd320;
   localparam logic [GFX_DIM_W-1:0] GFX_HEIGHT_RESET  = 11'd200;
   localparam logic [TXT_DIM_W-1:0] TEXT_WIDTH_RESET  = 8'd80;
   localparam logic [TXT_DIM_W-1:0] TEXT_HEIGHT_RESET = 8'd25;

   // cursor reset positions
   localparam logic [TXT_DIM_W-1:0] TEXT_X_RESET = 8'd40;
   localparam logic [TXT_DIM_W-1:0] TEXT_Y_RESET = 8'd12;
   localparam int                   GFX_X_RESET  = 160;
   localparam int                   GFX_Y_RESET  = 100;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_XDELTA = 2'd1,
      PH_YDELTA = 2'd2
   } phase_type;

   typedef struct packed {
      logic             packet_done;
      logic             byte_dropped;
      logic [OUT_W-1:0] cursor_x;
      logic [OUT_W-1:0] cursor_y;
      logic             left_click;
      logic             delta_overflow;
   } rsp_type;

endpackage

// ===== rtl/ps2_mouse_packet_cursor_tracker.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// Assembles PS/2 mouse bytes into 3-byte packets and tracks text and
// graphics cursors, one response per request byte.
//
//   channel | direction | payload
//   req     | in        | req_rx_byte
//   rsp     | out       | packet_done, byte_dropped, cursor_x/y, click, ovf
//   csr     | in        | csr_index, csr_wdata (always ready)
//
// One request per cycle while req_ready is high; its response is registered
// in output or skid. The packet state and cursors update in the accept cycle.
// A two-entry output buffer (output register plus skid) lets one more request
// in while a response stalls; req_ready drops only when the skid is full.
// Reset is synchronous and restores registers, cursors and packet phase.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_cursor_tracker_macros.svh"

module ps2_mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = pmct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pmct_pkg::BYTE_W-1:0]     req_rx_byte,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_packet_done,
   output logic                            rsp_byte_dropped,
   output logic [pmct_pkg::OUT_W-1:0]      rsp_cursor_x,
   output logic [pmct_pkg::OUT_W-1:0]      rsp_cursor_y,
   output logic                            rsp_left_click,
   output logic                            rsp_delta_overflow,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pmct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pmct_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CALC_W = ((COORD_BITS > pmct_pkg::GFX_DIM_W) ?
                            COORD_BITS : pmct_pkg::GFX_DIM_W) + 2;
   localparam logic signed [CALC_W-1:0] COORD_MAX = CALC_W'((1 << COORD_BITS) - 1);
   localparam int TW = pmct_pkg::TXT_CALC_W;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic                              graphics_mode_ff;
   logic [pmct_pkg::GFX_DIM_W-1:0]    gfx_width_ff;
   logic [pmct_pkg::GFX_DIM_W-1:0]    gfx_height_ff;
   logic [pmct_pkg::TXT_DIM_W-1:0]    text_width_ff;
   logic [pmct_pkg::TXT_DIM_W-1:0]    text_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         graphics_mode_ff <= 1'b0;
         gfx_width_ff     <= pmct_pkg::GFX_WIDTH_RESET;
         gfx_height_ff    <= pmct_pkg::GFX_HEIGHT_RESET;
         text_width_ff    <= pmct_pkg::TEXT_WIDTH_RESET;
         text_height_ff   <= pmct_pkg::TEXT_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pmct_pkg::CSR_GRAPHICS_MODE: graphics_mode_ff <= csr_wdata[0];
            pmct_pkg::CSR_GFX_WIDTH:     gfx_width_ff     <= csr_wdata;
            pmct_pkg::CSR_GFX_HEIGHT:    gfx_height_ff    <= csr_wdata;
            pmct_pkg::CSR_TEXT_WIDTH:    text_width_ff    <= csr_wdata[7:0];
            pmct_pkg::CSR_TEXT_HEIGHT:   text_height_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // packet and cursor state
   // ------------------------------------------------------------------------
   pmct_pkg::phase_type               phase_ff, phase_in;
   logic [pmct_pkg::BYTE_W-1:0]       header_ff, header_in;
   logic [pmct_pkg::BYTE_W-1:0]       xbyte_ff, xbyte_in;
   logic                              left_prev_ff, left_prev_in;
   logic [pmct_pkg::TXT_DIM_W-1:0]    text_x_ff, text_x_in;
   logic [pmct_pkg::TXT_DIM_W-1:0]    text_y_ff, text_y_in;
   logic [COORD_BITS-1:0]             gfx_x_ff, gfx_x_in;
   logic [COORD_BITS-1:0]             gfx_y_ff, gfx_y_in;

   pmct_pkg::rsp_type                 rsp_in;
   logic                              req_accept;

   assign req_accept = req_valid && req_ready;

   function automatic logic signed [CALC_W-1:0] clamp_g(
      input logic signed [CALC_W-1:0] v,
      input logic signed [CALC_W-1:0] lim
   );
      logic signed [CALC_W-1:0] r;
      if (v < 0) r = '0;
      else if (v > lim) r = lim;
      else r = v;
      return r;
   endfunction

   function automatic logic signed [TW-1:0] clamp_t(
      input logic signed [TW-1:0] v,
      input logic signed [TW-1:0] lim
   );
      logic signed [TW-1:0] r;
      if (v < 0) r = '0;
      else if (v > lim) r = lim;
      else r = v;
      return r;
   endfunction

   // next phase
   always_comb begin
      unique case (phase_ff)
         pmct_pkg::PH_HEADER:
            phase_in = ((req_rx_byte & pmct_pkg::SYNC_MASK) != '0) ?
                       pmct_pkg::PH_XDELTA : pmct_pkg::PH_HEADER;
         pmct_pkg::PH_XDELTA: phase_in = pmct_pkg::PH_YDELTA;
         pmct_pkg::PH_YDELTA: phase_in = pmct_pkg::PH_HEADER;
         default:             phase_in = pmct_pkg::PH_HEADER;
      endcase
   end

   // datapath and response
   logic                              is_header, is_xdelta;
   logic                              ovf, left, moved;
   logic signed [7:0]                 dx, dy;
   logic signed [8:0]                 dx2_t, dy2_t, dx4_t, dy4_t;
   logic signed [7:0]                 dx_half, dy_half, dx_qtr, dy_qtr;
   logic signed [CALC_W-1:0]          g_sum_x, g_sum_y, g_lim_x, g_lim_y;
   logic signed [CALC_W-1:0]          g_new_x, g_new_y;
   logic signed [TW-1:0]              t_sum_x, t_sum_y, t_lim_x, t_lim_y;
   logic signed [TW-1:0]              t_new_x, t_new_y;

   always_comb begin
      is_header = (phase_ff == pmct_pkg::PH_HEADER);
      is_xdelta = (phase_ff == pmct_pkg::PH_XDELTA);

      ovf  = (header_ff & pmct_pkg::OVERFLOW_MASK) != '0;
      left = (header_ff & pmct_pkg::LEFT_MASK) != '0;
      dx   = ovf ? 8'sd0 : signed'(xbyte_ff);
      dy   = ovf ? 8'sd0 : signed'(req_rx_byte);
      moved = (dx != 0) || (dy != 0);

      // divide with truncation toward zero: bias negatives before shifting
      dx2_t = 9'(dx) + signed'({8'b0, dx[7]});
      dy2_t = 9'(dy) + signed'({8'b0, dy[7]});
      dx4_t = 9'(dx) + signed'({7'b0, dx[7], dx[7]});
      dy4_t = 9'(dy) + signed'({7'b0, dy[7], dy[7]});
      dx_half = 8'(dx2_t >>> 1);
      dy_half = 8'(dy2_t >>> 1);
      dx_qtr  = 8'(dx4_t >>> 2);
      dy_qtr  = 8'(dy4_t >>> 2);

      // graphics limits: width-1, floored at zero, capped at coordinate max
      g_lim_x = signed'(CALC_W'(gfx_width_ff)) - CALC_W'(1);
      g_lim_y = signed'(CALC_W'(gfx_height_ff)) - CALC_W'(1);
      if (g_lim_x < 0) g_lim_x = '0;
      if (g_lim_y < 0) g_lim_y = '0;
      if (g_lim_x > COORD_MAX) g_lim_x = COORD_MAX;
      if (g_lim_y > COORD_MAX) g_lim_y = COORD_MAX;
      g_sum_x = signed'(CALC_W'(gfx_x_ff)) + CALC_W'(dx_half);
      g_sum_y = signed'(CALC_W'(gfx_y_ff)) - CALC_W'(dy_half);
      g_new_x = clamp_g(g_sum_x, g_lim_x);
      g_new_y = clamp_g(g_sum_y, g_lim_y);

      // text limits: width-1 and height-2, floored at zero
      t_lim_x = signed'(TW'(text_width_ff)) - TW'(1);
      t_lim_y = signed'(TW'(text_height_ff)) - TW'(2);
      if (t_lim_x < 0) t_lim_x = '0;
      if (t_lim_y < 0) t_lim_y = '0;
      t_sum_x = signed'(TW'(text_x_ff)) + TW'(dx_qtr);
      t_sum_y = signed'(TW'(text_y_ff)) - TW'(dy_qtr);
      t_new_x = clamp_t(t_sum_x, t_lim_x);
      t_new_y = clamp_t(t_sum_y, t_lim_y);

      header_in    = header_ff;
      xbyte_in     = xbyte_ff;
      left_prev_in = left_prev_ff;
      text_x_in    = text_x_ff;
      text_y_in    = text_y_ff;
      gfx_x_in     = gfx_x_ff;
      gfx_y_in     = gfx_y_ff;

      rsp_in = '0;

      if (is_header) begin
         if ((req_rx_byte & pmct_pkg::SYNC_MASK) == '0) begin
            rsp_in.byte_dropped = 1'b1;
         end else begin
            header_in = req_rx_byte;
         end
      end else if (is_xdelta) begin
         xbyte_in = req_rx_byte;
      end else begin
         rsp_in.packet_done    = 1'b1;
         rsp_in.delta_overflow = ovf;
         rsp_in.left_click     = left && !left_prev_ff;
         left_prev_in          = left;
         if (graphics_mode_ff) begin
            if (moved) begin
               gfx_x_in = COORD_BITS'(g_new_x);
               gfx_y_in = COORD_BITS'(g_new_y);
            end
         end else if (!ovf) begin
            text_x_in = t_new_x[7:0];
            text_y_in = t_new_y[7:0];
         end
      end

      if (graphics_mode_ff) begin
         rsp_in.cursor_x = pmct_pkg::OUT_W'(gfx_x_in);
         rsp_in.cursor_y = pmct_pkg::OUT_W'(gfx_y_in);
      end else begin
         rsp_in.cursor_x = pmct_pkg::OUT_W'(text_x_in);
         rsp_in.cursor_y = pmct_pkg::OUT_W'(text_y_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= pmct_pkg::PH_HEADER;
         header_ff    <= '0;
         xbyte_ff     <= '0;
         left_prev_ff <= 1'b0;
         text_x_ff    <= pmct_pkg::TEXT_X_RESET;
         text_y_ff    <= pmct_pkg::TEXT_Y_RESET;
         gfx_x_ff     <= COORD_BITS'(pmct_pkg::GFX_X_RESET);
         gfx_y_ff     <= COORD_BITS'(pmct_pkg::GFX_Y_RESET);
      end else if (req_accept) begin
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         xbyte_ff     <= xbyte_in;
         left_prev_ff <= left_prev_in;
         text_x_ff    <= text_x_in;
         text_y_ff    <= text_y_in;
         gfx_x_ff     <= gfx_x_in;
         gfx_y_ff     <= gfx_y_in;
      end
   end

   // ------------------------------------------------------------------------
   // output register with skid entry
   // ------------------------------------------------------------------------
   logic              out_valid_ff, skid_valid_ff;
   pmct_pkg::rsp_type out_ff, skid_ff;
   logic              out_free;

   assign req_ready = !skid_valid_ff;
   assign out_free  = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_free) begin
         if (req_accept) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_free) begin
         if (req_accept) begin
            skid_ff <= rsp_in;
         end
      end else if (skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (req_accept) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_packet_done    = out_ff.packet_done;
   assign rsp_byte_dropped   = out_ff.byte_dropped;
   assign rsp_cursor_x       = out_ff.cursor_x;
   assign rsp_cursor_y       = out_ff.cursor_y;
   assign rsp_left_click     = out_ff.left_click;
   assign rsp_delta_overflow = out_ff.delta_overflow;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   logic rsp_flag_any;

   assign rsp_flag_any = rsp_left_click || rsp_delta_overflow;

   `PMCT_ASSERT_IMPLY(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid without output")
   `PMCT_ASSERT_NEXT(a_stall_fills_skid, req_accept && !out_free, skid_valid_ff, "request lost")
   `PMCT_ASSERT_IMPLY(a_done_xor_drop, rsp_valid && rsp_byte_dropped, !rsp_packet_done, "both set")
   `PMCT_ASSERT_IMPLY(a_flags_done, rsp_valid && rsp_flag_any, rsp_packet_done, "flag alone")

endmodule

// ===== bench/ps2_mouse_packet_cursor_tracker_test.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_test
// Drives PS/2 mouse bytes and register writes into the cursor tracker and
// compares every response against a cycle-free model of packet assembly,
// sync dropping, overflow handling, click detection and cursor clamping.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_test;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_BYTES   = 400;
   localparam int COORD_MAX      = (1 << pmct_pkg::COORD_BITS_DEFAULT) - 1;

   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   logic [pmct_pkg::BYTE_W-1:0]     req_rx_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   logic                            rsp_packet_done;
   logic                            rsp_byte_dropped;
   logic [pmct_pkg::OUT_W-1:0]      rsp_cursor_x;
   logic [pmct_pkg::OUT_W-1:0]      rsp_cursor_y;
   logic                            rsp_left_click;
   logic                            rsp_delta_overflow;
   logic                            csr_valid   = 1'b0;
   logic                            csr_ready;
   logic [pmct_pkg::CSR_IDX_W-1:0]  csr_index   = '0;
   logic [pmct_pkg::CSR_DATA_W-1:0] csr_wdata   = '0;

   // model state
   logic                            mode_gfx;
   logic [pmct_pkg::GFX_DIM_W-1:0]  gfx_w, gfx_h;
   logic [pmct_pkg::TXT_DIM_W-1:0]  txt_w, txt_h;
   pmct_pkg::phase_type             pkt_phase;
   logic [pmct_pkg::BYTE_W-1:0]     pkt_header, pkt_xbyte;
   logic                            left_held;
   int                              text_x, text_y, gfx_x, gfx_y;

   pmct_pkg::rsp_type pending_cursor_reports[$];
   int      mismatch_count = 0;
   int      bytes_sent     = 0;
   int      stall_cycles   = 0;
   bit      no_gaps        = 1'b0;

   ps2_mouse_packet_cursor_tracker i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_packet_done    (rsp_packet_done),
      .rsp_byte_dropped   (rsp_byte_dropped),
      .rsp_cursor_x       (rsp_cursor_x),
      .rsp_cursor_y       (rsp_cursor_y),
      .rsp_left_click     (rsp_left_click),
      .rsp_delta_overflow (rsp_delta_overflow),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int clamp_coord(input int v, input int lim);
      if (lim < 0) lim = 0;
      if (v < 0) v = 0;
      if (v > lim) v = lim;
      return v;
   endfunction

   function automatic pmct_pkg::rsp_type track_mouse_byte(
      input logic [pmct_pkg::BYTE_W-1:0] b
   );
      pmct_pkg::rsp_type r;
      int                dx, dy, limx, limy;
      logic              left;
      r  = '0;
      dx = 0;
      dy = 0;
      case (pkt_phase)
         pmct_pkg::PH_HEADER: begin
            if ((b & pmct_pkg::SYNC_MASK) == '0) begin
               r.byte_dropped = 1'b1;
            end else begin
               pkt_header = b;
               pkt_phase  = pmct_pkg::PH_XDELTA;
            end
         end
         pmct_pkg::PH_XDELTA: begin
            pkt_xbyte = b;
            pkt_phase = pmct_pkg::PH_YDELTA;
         end
         default: begin
            pkt_phase        = pmct_pkg::PH_HEADER;
            r.packet_done    = 1'b1;
            r.delta_overflow = (pkt_header & pmct_pkg::OVERFLOW_MASK) != '0;
            if (!r.delta_overflow) begin
               dx = $signed(pkt_xbyte);
               dy = $signed(b);
            end
            left         = (pkt_header & pmct_pkg::LEFT_MASK) != '0;
            r.left_click = left && !left_held;
            left_held    = left;
            if (mode_gfx) begin
               // graphics cursor is only clamped when the delta is nonzero and not overflowed
               if (dx != 0 || dy != 0) begin
                  limx  = (int'(gfx_w) - 1 > COORD_MAX) ? COORD_MAX : int'(gfx_w) - 1;
                  limy  = (int'(gfx_h) - 1 > COORD_MAX) ? COORD_MAX : int'(gfx_h) - 1;
                  gfx_x = clamp_coord(gfx_x + dx / 2, limx);
                  gfx_y = clamp_coord(gfx_y - dy / 2, limy);
               end
            end else if (!r.delta_overflow) begin
               text_x = clamp_coord(text_x + dx / 4, int'(txt_w) - 1);
               text_y = clamp_coord(text_y - dy / 4, int'(txt_h) - 2);
            end
         end
      endcase
      r.cursor_x = mode_gfx ? gfx_x[pmct_pkg::OUT_W-1:0] : text_x[pmct_pkg::OUT_W-1:0];
      r.cursor_y = mode_gfx ? gfx_y[pmct_pkg::OUT_W-1:0] : text_y[pmct_pkg::OUT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
   endtask

   // response side: random back-pressure and checking
   always @(posedge clock) begin
      rsp_ready <= !reset && (no_gaps || $urandom_range(99) >= 31);
   end

   always @(posedge clock) begin : check_rsp
      pmct_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cursor_reports.size() == 0) begin
            report_mismatch("unexpected response", 0, 1);
         end else begin
            want = pending_cursor_reports.pop_front();
            if (rsp_packet_done !== want.packet_done)
               report_mismatch("packet_done", int'(want.packet_done),
                               int'(rsp_packet_done));
            if (rsp_byte_dropped !== want.byte_dropped)
               report_mismatch("byte_dropped", int'(want.byte_dropped),
                               int'(rsp_byte_dropped));
            if (rsp_cursor_x !== want.cursor_x)
               report_mismatch("cursor_x", int'(want.cursor_x), int'(rsp_cursor_x));
            if (rsp_cursor_y !== want.cursor_y)
               report_mismatch("cursor_y", int'(want.cursor_y), int'(rsp_cursor_y));
            if (rsp_left_click !== want.left_click)
               report_mismatch("left_click", int'(want.left_click), int'(rsp_left_click));
            if (rsp_delta_overflow !== want.delta_overflow)
               report_mismatch("delta_overflow", int'(want.delta_overflow),
                               int'(rsp_delta_overflow));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // request stays up across back-to-back bytes; lowered only for a gap
   task automatic send_mouse_byte(input logic [pmct_pkg::BYTE_W-1:0] b);
      if (!no_gaps && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 31);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      pending_cursor_reports.push_back(track_mouse_byte(b));
      bytes_sent++;
   endtask

   task automatic send_packet(input logic [pmct_pkg::BYTE_W-1:0] hdr, xd, yd);
      send_mouse_byte(hdr);
      send_mouse_byte(xd);
      send_mouse_byte(yd);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_cursor_reports.size() != 0);
   endtask

   // leaves csr_valid high; caller lowers it after the last write
   task automatic write_reg(input logic [pmct_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pmct_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pmct_pkg::CSR_GRAPHICS_MODE: mode_gfx = data[0];
         pmct_pkg::CSR_GFX_WIDTH:     gfx_w    = data[pmct_pkg::GFX_DIM_W-1:0];
         pmct_pkg::CSR_GFX_HEIGHT:    gfx_h    = data[pmct_pkg::GFX_DIM_W-1:0];
         pmct_pkg::CSR_TEXT_WIDTH:    txt_w    = data[pmct_pkg::TXT_DIM_W-1:0];
         pmct_pkg::CSR_TEXT_HEIGHT:   txt_h    = data[pmct_pkg::TXT_DIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic mode,
                                 input logic [pmct_pkg::GFX_DIM_W-1:0] gw, gh,
                                 input logic [pmct_pkg::TXT_DIM_W-1:0] tw, th,
                                 input bit stray);
      wait_idle();
      write_reg(pmct_pkg::CSR_GRAPHICS_MODE, pmct_pkg::CSR_DATA_W'(mode));
      write_reg(pmct_pkg::CSR_GFX_WIDTH, gw);
      write_reg(pmct_pkg::CSR_GFX_HEIGHT, gh);
      write_reg(pmct_pkg::CSR_TEXT_WIDTH, pmct_pkg::CSR_DATA_W'(tw));
      write_reg(pmct_pkg::CSR_TEXT_HEIGHT, pmct_pkg::CSR_DATA_W'(th));
      // unmapped index must not disturb anything
      if (stray)
         write_reg(pmct_pkg::CSR_TEXT_HEIGHT +
                   pmct_pkg::CSR_IDX_W'(1 + $urandom_range(2)),
                   pmct_pkg::CSR_DATA_W'($urandom_range(2047)));
      csr_valid <= 1'b0;
   endtask

   task automatic test_text_defaults();
      send_packet(8'h09, 8'h7F, 8'h80);   // full positive X, full negative Y, click
   endtask

   task automatic test_sync_drop();
      send_mouse_byte(8'h00);
      send_mouse_byte(8'hF7);
      send_packet(8'h08, 8'h80, 8'h7F);   // release, full negative X
   endtask

   task automatic test_overflow();
      send_packet(8'hC9, 8'h7F, 8'h7F);   // movement ignored, click still seen
   endtask

   task automatic test_graphics_caps();
      apply_settings(1'b1, 11'd2047, 11'd2047, pmct_pkg::TEXT_WIDTH_RESET,
                     pmct_pkg::TEXT_HEIGHT_RESET, 1'b1);
      send_packet(8'h08, 8'h01, 8'h00);   // halves to zero but still clamps
   endtask

   task automatic test_shrunk_limits();
      apply_settings(1'b1, 11'd0, 11'd1, 8'd1, 8'd0, 1'b0);
      send_packet(8'h08, 8'h00, 8'h00);   // zero delta: graphics cursor untouched
      send_packet(8'h48, 8'h10, 8'h10);   // overflow: no clamp either
      send_packet(8'h08, 8'hFF, 8'h00);   // nonzero delta: clamps to zero
      apply_settings(1'b0, 11'd0, 11'd1, 8'd1, 8'd0, 1'b0);
      send_packet(8'h08, 8'h00, 8'h00);   // text clamps even with zero delta
   endtask

   function automatic logic [pmct_pkg::GFX_DIM_W-1:0] pick_gfx_dim();
      case ($urandom_range(9))
         0: return 11'd2;
         1: return 11'd1024;
         2: return pmct_pkg::GFX_DIM_W'($urandom_range(2047));
         default: return pmct_pkg::GFX_DIM_W'($urandom_range(2, 1024));
      endcase
   endfunction

   function automatic logic [pmct_pkg::TXT_DIM_W-1:0] pick_text_dim();
      case ($urandom_range(9))
         0: return 8'd2;
         1: return 8'd255;
         2: return pmct_pkg::TXT_DIM_W'($urandom_range(255));
         default: return pmct_pkg::TXT_DIM_W'($urandom_range(2, 80));
      endcase
   endfunction

   function automatic logic [pmct_pkg::BYTE_W-1:0] pick_delta();
      case ($urandom_range(3))
         0: return pmct_pkg::BYTE_W'($urandom_range(255));
         1: return pmct_pkg::BYTE_W'($urandom_range(15));
         2: return pmct_pkg::BYTE_W'(-$urandom_range(1, 15));
         default: return $urandom_range(1) ? 8'h7F : 8'h80;
      endcase
   endfunction

   task automatic test_random_traffic();
      logic [pmct_pkg::BYTE_W-1:0] hdr;
      int                          phase_idx, n;
      phase_idx = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         apply_settings(1'($urandom_range(1)), pick_gfx_dim(), pick_gfx_dim(),
                        pick_text_dim(), pick_text_dim(), $urandom_range(2) == 0);
         no_gaps = (phase_idx == 2);
         n = $urandom_range(10, 25);
         repeat (n) begin
            if ($urandom_range(9) == 0) begin
               // noise, may misalign
               send_mouse_byte(pmct_pkg::BYTE_W'($urandom_range(255)));
            end else begin
               hdr = pmct_pkg::BYTE_W'($urandom_range(255));
               if ($urandom_range(7) != 0) hdr &= ~pmct_pkg::OVERFLOW_MASK;
               send_packet(hdr | pmct_pkg::SYNC_MASK, pick_delta(), pick_delta());
            end
         end
         no_gaps = 1'b0;
         phase_idx++;
      end
   endtask

   initial begin
      mode_gfx   = 1'b0;
      gfx_w      = pmct_pkg::GFX_WIDTH_RESET;
      gfx_h      = pmct_pkg::GFX_HEIGHT_RESET;
      txt_w      = pmct_pkg::TEXT_WIDTH_RESET;
      txt_h      = pmct_pkg::TEXT_HEIGHT_RESET;
      pkt_phase  = pmct_pkg::PH_HEADER;
      pkt_header = '0;
      pkt_xbyte  = '0;
      left_held  = 1'b0;
      text_x     = int'(pmct_pkg::TEXT_X_RESET);
      text_y     = int'(pmct_pkg::TEXT_Y_RESET);
      gfx_x      = pmct_pkg::GFX_X_RESET;
      gfx_y      = pmct_pkg::GFX_Y_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_text_defaults();
      test_sync_drop();
      test_overflow();
      test_graphics_caps();
      test_shrunk_limits();
      test_random_traffic();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_cursor_reports.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pmct_pkg.sv
rtl/ps2_mouse_packet_cursor_tracker.sv
bench/ps2_mouse_packet_cursor_tracker_test.sv
